[rtl/core/lesf_pkg.sv]
package lesf_pkg;

  // Widths of the configuration port and the result fields.
  localparam int CFG_W  = 11;
  localparam int IDX_W  = 1;
  localparam int SIZE_W = 11;
  localparam int POS_W  = 10;

  // Value both grid registers take at reset.
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1024);

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    REG_ROW_WIDTH = 1'b0,
    REG_ROW_COUNT = 1'b1
  } cfg_reg_t;

endpackage

[rtl/core/lesf_line_buf.sv]
module lesf_line_buf #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 11
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_mem;
  logic [WIDTH-1:0] byp_data;
  logic             bypass;

  // A read that meets a write to the same entry in the same cycle returns
  // the new data; the memory itself reads the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_mem   <= mem[raddr];
      bypass   <= we && (waddr == raddr);
      byp_data <= wdata;
    end
  end

  assign rdata = bypass ? byp_data : rd_mem;

endmodule

[rtl/core/largest_empty_square_finder.sv]
// A cell accepted at one clock edge is scored at the next edge; scoring the last
// cell of a grid loads the grid's best square into a free result slot.
// Throughput: one cell per cycle. Two result slots hold finished squares, and
// the last cell of a grid waits only while both slots could still be full
// when it is scored. Reset (rst, synchronous): both grid registers go to 1024,
// the position, best-square and result state clear; the line buffer is not.
module largest_empty_square_finder import lesf_pkg::*; #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              cell_valid,
  output logic              cell_stall,
  input  logic              is_obstacle,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [SIZE_W-1:0] square_size,
  output logic [POS_W-1:0]  top_row,
  output logic [POS_W-1:0]  left_col
);

  // Column and row indexes, and the width of a square side. A side never
  // exceeds the larger grid dimension.
  localparam int CW   = $clog2(MAX_COLS);
  localparam int RW   = $clog2(MAX_ROWS);
  localparam int CWP  = CW + 1;
  localparam int RWP  = RW + 1;
  localparam int MAXD = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
  localparam int SW   = $clog2(MAXD + 1);

  // ---------------------------------------------------------------------
  // Config registers: users write only while the block is idle; unchecked.
  // ---------------------------------------------------------------------
  logic [CFG_W-1:0] row_width;
  logic [CFG_W-1:0] row_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= CFG_RESET;
      row_count <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ROW_WIDTH: row_width <= cfg_data;
        REG_ROW_COUNT: row_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // A zero register acts as one; a value above the build limit acts as the
  // limit.
  logic [CWP-1:0] width_eff;
  logic [RWP-1:0] height_eff;

  always_comb begin
    if (row_width == '0) begin
      width_eff = CWP'(1);
    end else if (int'(row_width) > MAX_COLS) begin
      width_eff = CWP'(MAX_COLS);
    end else begin
      width_eff = CWP'(row_width);
    end
    if (row_count == '0) begin
      height_eff = RWP'(1);
    end else if (int'(row_count) > MAX_ROWS) begin
      height_eff = RWP'(MAX_ROWS);
    end else begin
      height_eff = RWP'(row_count);
    end
  end

  // ---------------------------------------------------------------------
  // Accept stage: raster position counters and the line buffer read.
  // ---------------------------------------------------------------------
  logic [CW-1:0]  col_pos;
  logic [RW-1:0]  row_pos;
  logic [CWP-1:0] col_inc;
  logic [RWP-1:0] row_inc;
  logic           col_wrap;
  logic           row_wrap;
  logic           offered_last;
  logic           cell_accept;

  // Second stage registers, declared here since the stall looks at them.
  logic          s1_valid;
  logic          s1_obst;
  logic [CW-1:0] s1_col;
  logic [RW-1:0] s1_row;
  logic          s1_row_end;
  logic          s1_last;

  // Second result slot and the slot count, also seen by the stall.
  logic              hold_valid;
  logic [SIZE_W-1:0] hold_size;
  logic [POS_W-1:0]  hold_row;
  logic [POS_W-1:0]  hold_col;
  logic              result_take;
  logic [1:0]        slots_after;

  assign col_inc      = {1'b0, col_pos} + CWP'(1);
  assign row_inc      = {1'b0, row_pos} + RWP'(1);
  assign col_wrap     = !(col_inc < width_eff);
  assign row_wrap     = !(row_inc < height_eff);
  assign offered_last = col_wrap && row_wrap;

  // Slots still taken after this edge, counting a finished grid that is
  // being scored now. Only the last cell of a grid can be held back: it is
  // taken when at most one slot is busy after this edge, so a slot is sure
  // to be free when it is scored. Every other cell flows even while finished
  // results wait downstream.
  assign result_take = result_valid && !result_stall;
  assign slots_after = 2'(result_valid) + 2'(hold_valid) + 2'(s1_valid && s1_last)
                       - 2'(result_take);
  assign cell_stall  = offered_last && (slots_after > 2'd1);
  assign cell_accept = cell_valid && !cell_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (cell_accept) begin
      if (col_wrap) begin
        col_pos <= '0;
        if (row_wrap) begin
          row_pos <= '0;
        end else begin
          row_pos <= row_inc[RW-1:0];
        end
      end else begin
        col_pos <= col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= cell_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (cell_accept) begin
      s1_obst    <= is_obstacle;
      s1_col     <= col_pos;
      s1_row     <= row_pos;
      s1_row_end <= col_wrap;
      s1_last    <= offered_last;
    end
  end

  // The line buffer holds the previous row's sides. Each scored cell writes
  // its side back at its own column in the cycle after its read. With a
  // one-column grid the next cell reads that same entry in that cycle; the
  // buffer forwards the fresh value in that case.
  logic [SW-1:0] up;
  logic [SW-1:0] cur;

  lesf_line_buf #(
    .DEPTH (MAX_COLS),
    .WIDTH (SW)
  ) u_line_buf (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_col),
    .wdata (cur),
    .re    (cell_accept),
    .raddr (col_pos),
    .rdata (up)
  );

  // ---------------------------------------------------------------------
  // Score stage: side of the largest free square ending at this cell and
  // the running best square of the grid.
  // ---------------------------------------------------------------------
  logic [SW-1:0] left_size;
  logic [SW-1:0] diag_size;
  logic [SW-1:0] top_side;
  logic [RW-1:0] best_row;
  logic [CW-1:0] best_col;

  logic [SW-1:0] min_ul;
  logic [SW-1:0] min_all;
  logic [SW-1:0] cur_raw;
  logic [SW-1:0] row_lim;
  logic [SW-1:0] cand_row;
  logic [SW-1:0] cand_col;
  logic          better;
  logic [SW-1:0] top_side_next;
  logic [RW-1:0] best_row_next;
  logic [CW-1:0] best_col_next;

  always_comb begin
    min_ul  = (up < left_size) ? up : left_size;
    min_all = (min_ul < diag_size) ? min_ul : diag_size;
    row_lim = SW'(s1_row) + SW'(1);

    if (s1_obst) begin
      cur_raw = '0;
    end else if ((s1_row == '0) || (s1_col == '0)) begin
      cur_raw = SW'(1);
    end else begin
      cur_raw = min_all + SW'(1);
    end

    // A stale line buffer entry must never push the top edge above row 0.
    cur = (cur_raw > row_lim) ? row_lim : cur_raw;

    // Only a strictly larger square replaces the best one, so the topmost
    // and then leftmost of equal squares is kept.
    better   = cur > top_side;
    cand_row = row_lim - cur;
    cand_col = SW'(s1_col) + SW'(1) - cur;

    if (better) begin
      top_side_next = cur;
      best_row_next = RW'(cand_row);
      best_col_next = CW'(cand_col);
    end else begin
      top_side_next = top_side;
      best_row_next = best_row;
      best_col_next = best_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_size <= '0;
      diag_size <= '0;
      top_side  <= '0;
      best_row  <= '0;
      best_col  <= '0;
    end else if (s1_valid) begin
      // The left and diagonal neighbors restart at each new row.
      if (s1_row_end) begin
        left_size <= '0;
        diag_size <= '0;
      end else begin
        left_size <= cur;
        diag_size <= up;
      end
      // A finished grid hands its best square to the result slots and the
      // search starts over.
      if (s1_last) begin
        top_side <= '0;
        best_row <= '0;
        best_col <= '0;
      end else begin
        top_side <= top_side_next;
        best_row <= best_row_next;
        best_col <= best_col_next;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result slots. The output register presents the oldest square; a second
  // slot keeps the next one while the output register waits. The stall
  // rule guarantees a free slot whenever a grid finishes, so the score
  // stage never waits on the output side.
  // ---------------------------------------------------------------------
  logic              load_result;
  logic [SIZE_W-1:0] new_size;
  logic [POS_W-1:0]  new_row;
  logic [POS_W-1:0]  new_col;

  assign load_result = s1_valid && s1_last;
  assign new_size    = SIZE_W'(top_side_next);
  assign new_row     = (top_side_next != '0) ? POS_W'(best_row_next) : '0;
  assign new_col     = (top_side_next != '0) ? POS_W'(best_col_next) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      hold_valid   <= 1'b0;
    end else if (result_take) begin
      result_valid <= hold_valid || load_result;
      hold_valid   <= hold_valid && load_result;
    end else if (load_result) begin
      result_valid <= 1'b1;
      hold_valid   <= result_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (result_take) begin
      if (hold_valid) begin
        square_size <= hold_size;
        top_row     <= hold_row;
        left_col    <= hold_col;
        if (load_result) begin
          hold_size <= new_size;
          hold_row  <= new_row;
          hold_col  <= new_col;
        end
      end else if (load_result) begin
        square_size <= new_size;
        top_row     <= new_row;
        left_col    <= new_col;
      end
    end else if (load_result) begin
      if (result_valid) begin
        hold_size <= new_size;
        hold_row  <= new_row;
        hold_col  <= new_col;
      end else begin
        square_size <= new_size;
        top_row     <= new_row;
        left_col    <= new_col;
      end
    end
  end

endmodule

[tb/largest_empty_square_finder_test.sv]
`timescale 1ns / 1ps

module largest_empty_square_finder_test;
  import lesf_pkg::*;

  localparam int COLS_LIMIT = 1024;
  localparam int ROWS_LIMIT = 1024;

  // One reported square: its side and the top-left corner.
  typedef struct {
    logic [SIZE_W-1:0] size;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
  } square_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [IDX_W-1:0]  cfg_index = REG_ROW_WIDTH;
  logic [CFG_W-1:0]  cfg_data = '0;
  logic              cell_valid = 1'b0;
  logic              cell_stall;
  logic              is_obstacle = 1'b0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  logic [SIZE_W-1:0] square_size;
  logic [POS_W-1:0]  top_row;
  logic [POS_W-1:0]  left_col;

  largest_empty_square_finder #(
    .MAX_COLS(COLS_LIMIT),
    .MAX_ROWS(ROWS_LIMIT)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cell_valid(cell_valid),
    .cell_stall(cell_stall),
    .is_obstacle(is_obstacle),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .square_size(square_size),
    .top_row(top_row),
    .left_col(left_col)
  );

  always #6 clk = ~clk;

  // Cells waiting to be driven, and squares the predictor has announced but
  // the block has not yet delivered.
  bit      cell_queue[$];
  square_t pending_squares[$];

  // Percent of cycles in which each side holds back.
  int sender_idle = 27;
  int receiver_idle = 71;
  int mismatches = 0;

  // Our copy of the grid registers, as raw 11-bit values.
  logic [CFG_W-1:0] grid_width = CFG_RESET;
  logic [CFG_W-1:0] grid_height = CFG_RESET;

  // Scan state of the square predictor. The line buffer holds the sides
  // computed for the previous row, indexed by column.
  int unsigned above_sizes[COLS_LIMIT];
  int unsigned left_side = 0;
  int unsigned diag_side = 0;
  int unsigned scan_row = 0;
  int unsigned scan_col = 0;
  int unsigned best_side = 0;
  int unsigned best_top = 0;
  int unsigned best_left = 0;

  initial begin
    foreach (above_sizes[i]) above_sizes[i] = 0;
  end

  // A register value of zero behaves as one; anything past the limit
  // behaves as the limit.
  function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return 32'(v);
  endfunction

  // Scores one accepted cell and, when it closes the grid, queues the
  // square the block has to report.
  task automatic score_cell(input bit obstacle);
    int unsigned w, h, c, up, side;
    square_t found;
    w = clamp_dim(grid_width, COLS_LIMIT);
    h = clamp_dim(grid_height, ROWS_LIMIT);
    c = (scan_col < COLS_LIMIT) ? scan_col : COLS_LIMIT - 1;
    up = above_sizes[c];
    if (obstacle) begin
      side = 0;
    end else if (scan_row == 0 || c == 0) begin
      side = 1;
    end else begin
      side = up < left_side ? up : left_side;
      side = 1 + (side < diag_side ? side : diag_side);
    end
    // A square may never reach above the first row, even when the line
    // buffer holds sides from an earlier, wider grid.
    if (side > scan_row + 1) side = scan_row + 1;
    // Strictly larger only: on a tie the earlier square stays.
    if (side > best_side) begin
      best_side = side;
      best_top = scan_row + 1 - side;
      best_left = c + 1 - side;
    end
    diag_side = up;
    left_side = side;
    above_sizes[c] = side;
    if (c + 1 < w) begin
      scan_col = c + 1;
    end else begin
      scan_col = 0;
      left_side = 0;
      diag_side = 0;
      if (scan_row + 1 < h) begin
        scan_row = scan_row + 1;
      end else begin
        found.size = best_side[SIZE_W-1:0];
        found.row = best_side != 0 ? best_top[POS_W-1:0] : '0;
        found.col = best_side != 0 ? best_left[POS_W-1:0] : '0;
        pending_squares.push_back(found);
        scan_row = 0;
        best_side = 0;
        best_top = 0;
        best_left = 0;
      end
    end
  endtask

  // Cell driver. A new transaction is offered only once the previous one
  // has been taken, so a stalled cell never changes under the block.
  always @(posedge clk) begin
    if (rst) begin
      cell_valid <= 1'b0;
    end else begin
      if (cell_valid && !cell_stall) score_cell(is_obstacle);
      if (!(cell_valid && cell_stall)) begin
        if (cell_queue.size() > 0 && $urandom_range(99) >= sender_idle) begin
          cell_valid <= 1'b1;
          is_obstacle <= cell_queue.pop_front();
        end else begin
          cell_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Every delivered square is checked against the oldest
  // one announced; the stall is redrawn each cycle.
  always @(posedge clk) begin
    square_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (pending_squares.size() == 0) begin
          $error("result transaction with none outstanding: size %0d row %0d col %0d",
                 square_size, top_row, left_col);
          mismatches++;
        end else begin
          want = pending_squares.pop_front();
          if (square_size !== want.size) begin
            $error("square_size: expected %0d, actual %0d", want.size, square_size);
            mismatches++;
          end
          if (top_row !== want.row) begin
            $error("top_row: expected %0d, actual %0d", want.row, top_row);
            mismatches++;
          end
          if (left_col !== want.col) begin
            $error("left_col: expected %0d, actual %0d", want.col, left_col);
            mismatches++;
          end
        end
      end
      result_stall <= ($urandom_range(99) < receiver_idle);
    end
  end

  // Waits until every queued cell has been taken and every announced square
  // has come back, then waits on so the pipeline is truly empty.
  // The check runs on the falling edge, when the driver has settled.
  task automatic wait_idle();
    while (cell_queue.size() > 0 || cell_valid || pending_squares.size() > 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // A register write takes effect at the edge where the enable is seen high.
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_ROW_WIDTH) grid_width = value;
    else grid_height = value;
  endtask

  task automatic set_grid(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    wait_idle();
    write_reg(REG_ROW_WIDTH, w);
    write_reg(REG_ROW_COUNT, h);
  endtask

  task automatic queue_grid(input int cells, input int obstacle_pct);
    repeat (cells) cell_queue.push_back($urandom_range(99) < obstacle_pct);
  endtask

  // A grid of obstacles whose only free spot is its very last position.
  task automatic queue_last_free(input int cells);
    repeat (cells - 1) cell_queue.push_back(1'b1);
    cell_queue.push_back(1'b0);
  endtask

  initial begin
    int random_cells;
    int cells;
    int copies;
    logic [CFG_W-1:0] w_val;
    logic [CFG_W-1:0] h_val;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Both registers at zero act as a single-position grid: one free
    // position, then one obstacle, back to back.
    set_grid(CFG_W'(0), CFG_W'(0));
    cell_queue.push_back(1'b0);
    cell_queue.push_back(1'b1);

    // A fully free 3x3 grid. The sender stops partway through and waits
    // for every outstanding square before finishing the grid.
    set_grid(CFG_W'(3), CFG_W'(3));
    repeat (4) cell_queue.push_back(1'b0);
    wait_idle();
    repeat (5) cell_queue.push_back(1'b0);

    // Two equal 2x2 squares split by an obstacle column; the left one,
    // found first, must be the one reported.
    set_grid(CFG_W'(5), CFG_W'(2));
    for (int r = 0; r < 2; r++)
      for (int c = 0; c < 5; c++)
        cell_queue.push_back(c == 2);

    // An oversized width acts as the full row, and the only free position
    // sits in the last column.
    set_grid(CFG_W'(2047), CFG_W'(1));
    queue_last_free(COLS_LIMIT);

    // Random grids, mostly small so that many squares are reported. The
    // directed grids above ran with the results stalled heavily; the first
    // half of these starves the block of cells, and the rest runs at full
    // rate. Copies of a grid follow each other with no register write in
    // between, so finished squares can pile up at the output.
    random_cells = 0;
    while (random_cells < 560) begin
      w_val = CFG_W'($urandom_range(1, 8));
      h_val = CFG_W'($urandom_range(1, 8));
      case ($urandom_range(19))
        0: w_val = '0;
        1: h_val = '0;
        2, 3: begin
          w_val = CFG_W'(1);
          h_val = CFG_W'(1);
        end
        default: ;
      endcase
      set_grid(w_val, h_val);
      if (random_cells < 280) begin
        sender_idle = 71;
        receiver_idle = 27;
      end else begin
        sender_idle = 0;
        receiver_idle = 0;
      end
      cells = int'(clamp_dim(w_val, COLS_LIMIT) * clamp_dim(h_val, ROWS_LIMIT));
      copies = int'($urandom_range(1, 4));
      repeat (copies) queue_grid(cells, int'($urandom_range(0, 50)));
      random_cells += cells * copies;
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Safety net: a hung handshake or a square that never arrives ends here.
  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
